/* rtl/core/bmu_pkg.sv */
// Shared types and constants for the 64-bit bit-manipulation unit.
package bmu_pkg;

	localparam int unsigned WordBits = 64;
	localparam int unsigned IdxBits  = 6;
	localparam int unsigned OpBits   = 4;
	localparam int unsigned CntBits  = 7;

	typedef logic [WordBits-1:0] word_t;
	typedef logic [IdxBits-1:0]  idx_t;
	typedef logic [CntBits-1:0]  cnt_t;

	// Operation codes carried on the opcode field
	typedef enum logic [OpBits-1:0] {
		OP_AND      = 4'd0,
		OP_OR       = 4'd1,
		OP_XOR      = 4'd2,
		OP_NOT      = 4'd3,
		OP_SHL      = 4'd4,
		OP_SHR      = 4'd5,
		OP_TEST     = 4'd6,
		OP_SET      = 4'd7,
		OP_CLEAR    = 4'd8,
		OP_ROL      = 4'd9,
		OP_ROR      = 4'd10,
		OP_POPCOUNT = 4'd11
	} op_t;

	// One result beat
	typedef struct packed {
		word_t value;
		logic  range_err;
	} res_t;

endpackage

/* rtl/core/bmu_popcount.sv */
// Population count of a 64-bit word: per-byte counts and an adder tree.
module bmu_popcount (
	input  bmu_pkg::word_t data,
	output bmu_pkg::cnt_t  count
);
	import bmu_pkg::*;

	localparam int unsigned Bytes = WordBits / 8;

	logic [3:0] byte_cnt [Bytes];
	logic [4:0] sum_l1   [Bytes/2];
	logic [5:0] sum_l2   [Bytes/4];

	// Count ones in each byte
	always_comb begin
		for (int i = 0; i < Bytes; i++) begin
			byte_cnt[i] = '0;
			for (int j = 0; j < 8; j++) begin
				byte_cnt[i] = byte_cnt[i] + {3'd0, data[i*8+j]};
			end
		end
	end

	// Adder tree over the byte counts
	always_comb begin
		for (int i = 0; i < Bytes/2; i++) begin
			sum_l1[i] = {1'b0, byte_cnt[2*i]} + {1'b0, byte_cnt[2*i+1]};
		end
		for (int i = 0; i < Bytes/4; i++) begin
			sum_l2[i] = {1'b0, sum_l1[2*i]} + {1'b0, sum_l1[2*i+1]};
		end
	end

	assign count = {1'b0, sum_l2[0]} + {1'b0, sum_l2[1]};

endmodule

/* rtl/core/bmu_alu.sv */
// Combinational datapath: logic ops, shifts, single-bit ops, rotates, popcount.
module bmu_alu (
	input  logic [bmu_pkg::OpBits-1:0] opcode,
	input  bmu_pkg::word_t             operand_a,
	input  bmu_pkg::word_t             operand_b,
	output bmu_pkg::res_t              result
);
	import bmu_pkg::*;

	idx_t                 idx;
	logic                 idx_over;
	logic                 indexed;
	word_t                bit_mask;
	logic [2*WordBits-1:0] rol_full;
	logic [2*WordBits-1:0] ror_full;
	cnt_t                 pop_cnt;
	op_t                  op;

	assign op       = op_t'(opcode);
	assign idx      = operand_b[IdxBits-1:0];
	assign idx_over = |operand_b[WordBits-1:IdxBits];
	assign bit_mask = word_t'(1) << idx;
	assign rol_full = {operand_a, operand_a} << idx;
	assign ror_full = {operand_a, operand_a} >> idx;

	bmu_popcount u_popcount (
		.data  (operand_a),
		.count (pop_cnt)
	);

	// Ops whose operand_b is range-checked as a bit index (rotates use its low bits unchecked)
	always_comb begin
		case (op)
			OP_SHL, OP_SHR, OP_TEST, OP_SET, OP_CLEAR: indexed = 1'b1;
			default:                                   indexed = 1'b0;
		endcase
	end

	// Result select; out-of-range index on a range-checked op forces zero
	always_comb begin
		result.range_err = indexed & idx_over;
		case (op)
			OP_AND:      result.value = operand_a & operand_b;
			OP_OR:       result.value = operand_a | operand_b;
			OP_XOR:      result.value = operand_a ^ operand_b;
			OP_NOT:      result.value = ~operand_a;
			OP_SHL:      result.value = operand_a << idx;
			OP_SHR:      result.value = operand_a >> idx;
			OP_TEST:     result.value = {{(WordBits-1){1'b0}}, operand_a[idx]};
			OP_SET:      result.value = operand_a | bit_mask;
			OP_CLEAR:    result.value = operand_a & ~bit_mask;
			OP_ROL:      result.value = rol_full[2*WordBits-1:WordBits];
			OP_ROR:      result.value = ror_full[WordBits-1:0];
			OP_POPCOUNT: result.value = {{(WordBits-CntBits){1'b0}}, pop_cnt};
			default:     result.value = '0;
		endcase
		if (result.range_err) begin
			result.value = '0;
		end
	end

endmodule

/* rtl/core/bit_manipulation_unit_64.sv */
// Top level of the 64-bit bit-manipulation unit: input stage, datapath, result stage.
//
// Usage:
//   Input channel: in_valid / in_stall with opcode, operand_a, operand_b.
//   A beat is taken at a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with result_value, range_error.
//   Every input beat yields exactly one output beat, in order.
// Timing:
//   An input beat reaches out_valid through one register for the
//   operands and one for the result, with the whole operation evaluated
//   in a single pass between them.
//   Throughput is one beat per cycle while out_stall stays low.
// Stall:
//   While out_stall is high the result register holds its beat. The input
//   register still takes one more beat; in_stall rises only once both
//   registers are full, and falls in the cycle the output side drains.
// Reset:
//   arst_n clears both valid bits at once; no beats are in flight after it.
module bit_manipulation_unit_64 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bmu_pkg::OpBits-1:0]  opcode,
	input  bmu_pkg::word_t              operand_a,
	input  bmu_pkg::word_t              operand_b,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bmu_pkg::word_t              result_value,
	output logic                        range_error
);
	import bmu_pkg::*;

	logic              valid_s1;
	logic [OpBits-1:0] opcode_s1;
	word_t             operand_a_s1;
	word_t             operand_b_s1;
	logic              valid_s2;
	res_t              result_s2;
	res_t              alu_res;
	logic              load_s1;
	logic              load_s2;
	logic              ready_s1;
	logic              ready_s2;

	// Flow control: each stage moves when the next can take it
	assign ready_s2 = ~valid_s2 | ~out_stall;
	assign ready_s1 = ~valid_s1 | ready_s2;
	assign load_s1  = in_valid & ready_s1;
	assign load_s2  = valid_s1 & ready_s2;
	assign in_stall = ~ready_s1;

	// Operand register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			opcode_s1    <= opcode;
			operand_a_s1 <= operand_a;
			operand_b_s1 <= operand_b;
		end
	end

	bmu_alu u_alu (
		.opcode    (opcode_s1),
		.operand_a (operand_a_s1),
		.operand_b (operand_b_s1),
		.result    (alu_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= alu_res;
		end
	end

	assign out_valid    = valid_s2;
	assign result_value = result_s2.value;
	assign range_error  = result_s2.range_err;

endmodule

/* rtl/core/bmu_checker.sv */
// Port-level checks for the bit-manipulation unit, bound to the top level.
module bmu_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input bmu_pkg::word_t             result_value,
	input logic                       range_error
);

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(range_error))
		else $error("result beat changed while stalled");

	// A range error always carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> result_value == '0)
		else $error("range error with nonzero result");

	// Input backpressure only when the output side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// A fresh output beat follows an accepted input beat, through the operand and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output beat without matching input beat");

endmodule

bind bit_manipulation_unit_64 bmu_checker u_bmu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value),
	.range_error  (range_error)
);
